// ----- rtl/ale_pkg.sv -----
// ale_pkg: shared types, constants and decode helpers for the load emulator
// used by every module under rtl; depends on nothing
`default_nettype none
package ale_pkg;

  localparam int unsigned PageBytesDefault = 4096;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_BASE  = 1'b0,
    CFG_WINDOW_BYTES = 1'b1
  } cfg_index_t;

  typedef enum logic {
    OP_FILL    = 1'b0,
    OP_EMULATE = 1'b1
  } op_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] instruction;
    logic [63:0] inst_address;
    logic [63:0] base_value;
    logic [8:0]  fill_index;
    logic [63:0] fill_data;
  } in_item_t;

  typedef struct packed {
    logic        handled;
    logic        dest1_enable;
    logic [4:0]  dest1_index;
    logic [63:0] dest1_value;
    logic        dest2_enable;
    logic [4:0]  dest2_index;
    logic [63:0] dest2_value;
    logic        writeback_enable;
    logic [4:0]  writeback_index;
    logic [63:0] writeback_value;
    logic [63:0] next_pc;
  } out_item_t;

  // instruction match patterns
  localparam logic [31:0] LdrUoff64  = 32'hF940_0000;
  localparam logic [31:0] LdrUoff32  = 32'hB940_0000;
  localparam logic [31:0] LdrPre64   = 32'hF840_0C00;
  localparam logic [31:0] LdrPre32   = 32'hB840_0C00;
  localparam logic [31:0] LdrPost64  = 32'hF840_0400;
  localparam logic [31:0] LdrPost32  = 32'hB840_0400;
  localparam logic [31:0] LdrLit64   = 32'h5800_0000;
  localparam logic [31:0] LdrLit32   = 32'h1800_0000;
  localparam logic [31:0] LdrswLit   = 32'h9800_0000;
  localparam logic [31:0] Ldp64      = 32'hA940_0000;
  localparam logic [31:0] Ldp32      = 32'h2940_0000;
  localparam logic [31:0] Ldur64     = 32'hF840_0000;
  localparam logic [31:0] Ldur32     = 32'hB840_0000;
  localparam logic [31:0] MaskUoff   = 32'hFFC0_0000;
  localparam logic [31:0] MaskIdx    = 32'hFFE0_0C00;
  localparam logic [31:0] MaskLit    = 32'hFF00_0000;
  localparam logic [4:0]  RegZr      = 5'd31;

  // classified work handed from front to back
  typedef struct packed {
    logic        fill;
    logic [8:0]  fill_index;
    logic [63:0] fill_data;
    logic        hit;         // recognized and inside the window
    logic        pair;
    logic        wide;        // 8-byte elements
    logic        sx;
    logic [12:0] offset;      // byte offset into window
    logic        d1_en;
    logic [4:0]  rt;
    logic        d2_en;
    logic [4:0]  rt2;
    logic        wb_en;
    logic [4:0]  rn;
    logic [63:0] wb_value;
    logic [63:0] pc;
  } work_t;

endpackage
`default_nettype wire

// ----- rtl/ale_front.sv -----
// ale_front: decodes an item, forms the address and checks the window
// depends on ale_pkg
`default_nettype none
module ale_front #(
  parameter int unsigned PAGE_BYTES = ale_pkg::PageBytesDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ale_pkg::in_item_t item,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire logic [63:0]      window_base,
  input  wire logic [12:0]      window_bytes,
  output ale_pkg::work_t        work,
  output logic                  work_valid,
  input  wire logic             work_ready
);

  localparam logic [17:0] PageSize = 18'(PAGE_BYTES);

  logic [31:0] inst;
  logic [63:0] base;
  logic [63:0] imm9;
  logic [63:0] addr;
  logic [63:0] wbval;
  logic [4:0]  nbytes;
  logic        match;
  logic        pair;
  logic        wide;
  logic        sx;
  logic        wb;
  logic [63:0] off;
  logic [17:0] wsize;
  logic        in_win;
  ale_pkg::work_t w_next;

  assign inst = item.instruction;
  assign base = item.base_value;
  assign imm9 = {{55{inst[20]}}, inst[20:12]};

  // decode the thirteen forms, first match wins
  always_comb begin
    match = 1'b1;
    pair  = 1'b0;
    wide  = 1'b0;
    sx    = 1'b0;
    wb    = 1'b0;
    addr  = base;
    wbval = '0;
    priority if ((inst & ale_pkg::MaskUoff) == ale_pkg::LdrUoff64) begin
      wide = 1'b1;
      addr = base + {49'b0, inst[21:10], 3'b0};
    end else if ((inst & ale_pkg::MaskUoff) == ale_pkg::LdrUoff32) begin
      addr = base + {50'b0, inst[21:10], 2'b0};
    end else if ((inst & ale_pkg::MaskIdx) == ale_pkg::LdrPre64 ||
                 (inst & ale_pkg::MaskIdx) == ale_pkg::LdrPre32) begin
      wide  = inst[31:30] == 2'b11;
      addr  = base + imm9;
      wb    = 1'b1;
      wbval = base + imm9;
    end else if ((inst & ale_pkg::MaskIdx) == ale_pkg::LdrPost64 ||
                 (inst & ale_pkg::MaskIdx) == ale_pkg::LdrPost32) begin
      wide  = inst[31:30] == 2'b11;
      wb    = 1'b1;
      wbval = base + imm9;
    end else if ((inst & ale_pkg::MaskIdx) == ale_pkg::Ldur64 ||
                 (inst & ale_pkg::MaskIdx) == ale_pkg::Ldur32) begin
      wide = inst[31:30] == 2'b11;
      addr = base + imm9;
    end else if ((inst & ale_pkg::MaskLit) == ale_pkg::LdrLit64 ||
                 (inst & ale_pkg::MaskLit) == ale_pkg::LdrLit32 ||
                 (inst & ale_pkg::MaskLit) == ale_pkg::LdrswLit) begin
      wide = (inst & ale_pkg::MaskLit) == ale_pkg::LdrLit64;
      sx   = (inst & ale_pkg::MaskLit) == ale_pkg::LdrswLit;
      addr = item.inst_address + {{43{inst[23]}}, inst[23:5], 2'b0};
    end else if ((inst & ale_pkg::MaskUoff) == ale_pkg::Ldp64) begin
      wide = 1'b1;
      pair = 1'b1;
      addr = base + {{54{inst[21]}}, inst[21:15], 3'b0};
    end else if ((inst & ale_pkg::MaskUoff) == ale_pkg::Ldp32) begin
      pair = 1'b1;
      addr = base + {{55{inst[21]}}, inst[21:15], 2'b0};
    end else begin
      match = 1'b0;
    end
  end

  // window check: offset + n <= min(window_bytes, page)
  always_comb begin
    nbytes = wide ? (pair ? 5'd16 : 5'd8) : (pair ? 5'd8 : 5'd4);
    off    = addr - window_base;
    wsize  = ({5'b0, window_bytes} > PageSize) ? PageSize : {5'b0, window_bytes};
    in_win = (wsize >= {13'b0, nbytes}) &&
             (off <= {46'b0, wsize - {13'b0, nbytes}});
  end

  always_comb begin
    w_next            = '0;
    w_next.fill       = item.opcode == ale_pkg::OP_FILL;
    w_next.fill_index = item.fill_index;
    w_next.fill_data  = item.fill_data;
    w_next.pc         = item.inst_address;
    w_next.pair       = pair;
    w_next.wide       = wide;
    w_next.sx         = sx;
    w_next.offset     = off[12:0];
    w_next.rt         = inst[4:0];
    w_next.rt2        = inst[14:10];
    w_next.rn         = inst[9:5];
    w_next.wb_value   = wbval;
    w_next.hit        = !w_next.fill && match && in_win;
    w_next.d1_en      = w_next.hit && inst[4:0] != ale_pkg::RegZr;
    w_next.d2_en      = w_next.hit && pair && inst[14:10] != ale_pkg::RegZr;
    w_next.wb_en      = w_next.hit && wb && inst[9:5] != ale_pkg::RegZr;
  end

  // single register stage to the queue
  assign item_ready = !work_valid || work_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (item_ready) begin
      work_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      work <= w_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ale_queue.sv -----
// ale_queue: two-entry queue between the front and back parts
// depends on ale_pkg
`default_nettype none
module ale_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ale_pkg::work_t in_work,
  input  wire logic          in_valid,
  output logic               in_ready,
  output ale_pkg::work_t     out_work,
  output logic               out_valid,
  input  wire logic          out_ready
);

  ale_pkg::work_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_work  = slot[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  // pointer and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= in_work;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 2'd1)
    else $error("push without pop did not grow queue");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - 2'd1)
    else $error("pop without push did not shrink queue");

endmodule
`default_nettype wire

// ----- rtl/ale_back.sv -----
// ale_back: backup store, byte extraction and result register
// depends on ale_pkg
`default_nettype none
module ale_back #(
  parameter int unsigned PAGE_BYTES = ale_pkg::PageBytesDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ale_pkg::work_t  work,
  input  wire logic            work_valid,
  output logic                 work_ready,
  output ale_pkg::out_item_t   result,
  output logic                 empty,
  input  wire logic            pop
);

  localparam int unsigned Depth = (PAGE_BYTES + 7) / 8;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_SHOW  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [63:0] mem [Depth];
  logic [63:0] rd_lo;
  logic [63:0] rd_hi;
  logic [63:0] rd_lo2;
  logic        lo_sel;
  ale_pkg::work_t cur;
  logic [12:0] w0;
  logic [12:0] w1;
  logic [12:0] w2;
  logic [AW-1:0] rd_addr;
  logic [191:0] window;
  logic [127:0] bytes16;
  logic [63:0] v1;
  logic [63:0] v2;
  ale_pkg::out_item_t res_next;
  logic        accept;

  assign accept     = work_valid && work_ready;
  assign work_ready = state == ST_IDLE && empty;

  // control: take, read the upper words in ST_READ (fills skip it), then hold the result
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = work.fill ? ST_SHOW : ST_READ;
      ST_READ: if (!lo_sel) state_next = ST_SHOW;
      ST_SHOW: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      empty  <= 1'b1;
      lo_sel <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) lo_sel <= 1'b1;
      else if (state == ST_READ)      lo_sel <= 1'b0;
      if (state == ST_SHOW)           empty <= 1'b0;
      else if (pop && !empty)         empty <= 1'b1;
    end
  end

  // word addresses covering up to sixteen bytes
  assign w0 = {3'b0, cur.offset[12:3]};
  assign w1 = w0 + 13'd1;
  assign w2 = w0 + 13'd2;
  assign rd_addr = (state == ST_IDLE) ? AW'(work.offset[12:3]) :
                   lo_sel ? AW'(w1) : AW'(w2);

  // store: at most one write and one read per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= work;
      if (work.fill && 32'(work.fill_index) < Depth) begin
        mem[AW'(work.fill_index)] <= work.fill_data;
      end
    end
    if (state == ST_IDLE) begin
      rd_lo <= mem[rd_addr];
    end else if (state == ST_READ && lo_sel) begin
      rd_hi <= mem[rd_addr];
    end else if (state == ST_READ) begin
      rd_lo2 <= mem[rd_addr];
    end
  end

  // little-endian extraction
  always_comb begin
    window  = {rd_lo2, rd_hi, rd_lo};
    bytes16 = 128'(window >> {cur.offset[2:0], 3'b0});
    if (cur.wide) begin
      v1 = bytes16[63:0];
      v2 = bytes16[127:64];
    end else begin
      v1 = cur.sx ? {{32{bytes16[31]}}, bytes16[31:0]} : {32'b0, bytes16[31:0]};
      v2 = {32'b0, bytes16[63:32]};
    end
  end

  always_comb begin
    res_next                  = '0;
    res_next.handled          = cur.hit;
    res_next.dest1_enable     = cur.d1_en;
    res_next.dest1_index      = cur.d1_en ? cur.rt : 5'd0;
    res_next.dest1_value      = cur.d1_en ? v1 : 64'd0;
    res_next.dest2_enable     = cur.d2_en;
    res_next.dest2_index      = cur.d2_en ? cur.rt2 : 5'd0;
    res_next.dest2_value      = cur.d2_en ? v2 : 64'd0;
    res_next.writeback_enable = cur.wb_en;
    res_next.writeback_index  = cur.wb_en ? cur.rn : 5'd0;
    res_next.writeback_value  = cur.wb_en ? cur.wb_value : 64'd0;
    res_next.next_pc          = cur.hit ? cur.pc + 64'd4 : cur.pc;
  end

  always_ff @(posedge clk) begin
    if (state == ST_SHOW) begin
      result <= res_next;
    end
  end

  a_show_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHOW |-> empty) else $error("result overwritten before pop");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    accept |-> state == ST_IDLE) else $error("item taken while busy");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");

endmodule
`default_nettype wire

// ----- rtl/arm64_load_emulator.sv -----
// arm64_load_emulator: top level joining config, front, queue and back
// depends on ale_pkg, ale_front, ale_queue, ale_back
// an emulate passes the front register and the queue; the back part then reads the
// store in ST_READ (fills skip it) and loads the result register; it takes no new
// item until that result has been popped, so those reads and that wait limit its rate
// a result register holds one transaction; the front and queue accept until full
// reset (rst, synchronous): window_base 0, window_bytes 4096, queues empty
// the backup store is not cleared; unwritten words read as undefined
`default_nettype none
module arm64_load_emulator #(
  parameter int unsigned PAGE_BYTES = ale_pkg::PageBytesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ale_pkg::in_item_t  in_item,
  input  wire logic               push,
  output logic                    full,
  output ale_pkg::out_item_t      out_item,
  output logic                    empty,
  input  wire logic               pop,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data
);

  logic [63:0] window_base;
  logic [12:0] window_bytes;
  logic        front_ready;
  ale_pkg::work_t f_work;
  logic        f_valid;
  logic        f_ready;
  ale_pkg::work_t q_work;
  logic        q_valid;
  logic        q_ready;

  assign cfg_ready = 1'b1;
  assign full      = !front_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= '0;
      window_bytes <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ale_pkg::cfg_index_t'(cfg_index))
        ale_pkg::CFG_WINDOW_BASE:  window_base  <= cfg_data;
        ale_pkg::CFG_WINDOW_BYTES: window_bytes <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  ale_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk, .rst,
    .item(in_item), .item_valid(push), .item_ready(front_ready),
    .window_base, .window_bytes,
    .work(f_work), .work_valid(f_valid), .work_ready(f_ready)
  );

  ale_queue u_queue (
    .clk, .rst,
    .in_work(f_work), .in_valid(f_valid), .in_ready(f_ready),
    .out_work(q_work), .out_valid(q_valid), .out_ready(q_ready)
  );

  ale_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk, .rst,
    .work(q_work), .work_valid(q_valid), .work_ready(q_ready),
    .result(out_item), .empty, .pop
  );

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for arm64_load_emulator, driving fills and load
// emulation through the queue ports and checking every result against a local predictor
// or a typed row's given result; depends on ale_pkg and the arm64_load_emulator rtl
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned WINDOW_MAX = 4096;
  localparam int unsigned STORE_WORDS = 512;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 130;

  typedef struct {
    ale_pkg::in_item_t  item;
    bit                 typed;
    ale_pkg::out_item_t result;
  } dir_row_t;

  logic               clk;
  logic               rst;
  ale_pkg::in_item_t  in_item;
  logic               push;
  logic               full;
  ale_pkg::out_item_t out_item;
  logic               empty;
  logic               pop;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [63:0]        cfg_data;

  // local copy of block state and configuration
  logic [63:0] shadow_store [STORE_WORDS];
  logic [63:0] win_base;
  logic [12:0] win_bytes;

  ale_pkg::out_item_t pending_loads [$];
  dir_row_t    dir_tab [$];
  int          errors;
  int          cycles;
  int          n_checked;
  int          n_handled;
  bit          idle_on;
  int          hold_req;

  arm64_load_emulator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .push      (push),
    .full      (full),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] sext(logic [63:0] v, int bits);
    logic [63:0] m;
    m = 64'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] fetch_bytes(logic [63:0] off, int n);
    logic [63:0] v;
    logic [63:0] b;
    v = '0;
    for (int k = 0; k < n; k++) begin
      b = off + k;
      v[8*k +: 8] = shadow_store[b[11:3]][8*b[2:0] +: 8];
    end
    return v;
  endfunction

  // predicted result of one transaction; fills update the shadow store
  function automatic ale_pkg::out_item_t predict_load(ale_pkg::in_item_t it);
    ale_pkg::out_item_t r;
    logic [31:0] ins;
    logic [4:0]  rt, rn, rt2;
    logic [63:0] addr, wbval, off, wsize, n, imm9;
    int          size;
    bit          pair, sx, wb;
    r = '0;
    r.next_pc = it.inst_address;
    if (it.opcode == ale_pkg::OP_FILL) begin
      shadow_store[it.fill_index] = it.fill_data;
      return r;
    end
    ins = it.instruction;
    rt = ins[4:0];
    rn = ins[9:5];
    rt2 = ins[14:10];
    imm9 = sext(64'(ins[20:12]), 9);
    size = 0;
    pair = 0;
    sx = 0;
    wb = 0;
    addr = '0;
    wbval = '0;
    if ((ins & ale_pkg::MaskUoff) == ale_pkg::LdrUoff64) begin
      size = 8; addr = it.base_value + 64'(ins[21:10]) * 8;
    end else if ((ins & ale_pkg::MaskUoff) == ale_pkg::LdrUoff32) begin
      size = 4; addr = it.base_value + 64'(ins[21:10]) * 4;
    end else if ((ins & ale_pkg::MaskIdx) == ale_pkg::LdrPre64 ||
                 (ins & ale_pkg::MaskIdx) == ale_pkg::LdrPre32) begin
      size = (ins[31:30] == 2'b11) ? 8 : 4;
      addr = it.base_value + imm9; wb = 1; wbval = addr;
    end else if ((ins & ale_pkg::MaskIdx) == ale_pkg::LdrPost64 ||
                 (ins & ale_pkg::MaskIdx) == ale_pkg::LdrPost32) begin
      size = (ins[31:30] == 2'b11) ? 8 : 4;
      addr = it.base_value; wb = 1; wbval = it.base_value + imm9;
    end else if ((ins & ale_pkg::MaskIdx) == ale_pkg::Ldur64 ||
                 (ins & ale_pkg::MaskIdx) == ale_pkg::Ldur32) begin
      size = (ins[31:30] == 2'b11) ? 8 : 4;
      addr = it.base_value + imm9;
    end else if ((ins & ale_pkg::MaskLit) == ale_pkg::LdrLit64 ||
                 (ins & ale_pkg::MaskLit) == ale_pkg::LdrLit32 ||
                 (ins & ale_pkg::MaskLit) == ale_pkg::LdrswLit) begin
      size = ((ins & ale_pkg::MaskLit) == ale_pkg::LdrLit64) ? 8 : 4;
      sx = ((ins & ale_pkg::MaskLit) == ale_pkg::LdrswLit);
      addr = it.inst_address + sext(64'(ins[23:5]), 19) * 4;
    end else if ((ins & ale_pkg::MaskUoff) == ale_pkg::Ldp64 ||
                 (ins & ale_pkg::MaskUoff) == ale_pkg::Ldp32) begin
      size = ((ins & ale_pkg::MaskUoff) == ale_pkg::Ldp64) ? 8 : 4;
      pair = 1;
      addr = it.base_value + sext(64'(ins[21:15]), 7) * 64'(size);
    end
    if (size == 0) return r;
    // window check, no wraparound past the end
    wsize = (win_bytes > WINDOW_MAX) ? 64'(WINDOW_MAX) : 64'(win_bytes);
    n = 64'(pair ? 2 * size : size);
    off = addr - win_base;
    if (wsize < n || off > wsize - n) return r;
    r.handled = 1'b1;
    if (rt != ale_pkg::RegZr) begin
      r.dest1_enable = 1'b1;
      r.dest1_index = rt;
      r.dest1_value = fetch_bytes(off, size);
      if (sx) r.dest1_value = sext(r.dest1_value, 32);
    end
    if (pair && rt2 != ale_pkg::RegZr) begin
      r.dest2_enable = 1'b1;
      r.dest2_index = rt2;
      r.dest2_value = fetch_bytes(off + 64'(size), size);
    end
    if (wb && rn != ale_pkg::RegZr) begin
      r.writeback_enable = 1'b1;
      r.writeback_index = rn;
      r.writeback_value = wbval;
    end
    r.next_pc = it.inst_address + 64'd4;
    return r;
  endfunction

  function automatic ale_pkg::in_item_t mk_fill(logic [8:0] idx, logic [63:0] data);
    ale_pkg::in_item_t it;
    it.opcode = ale_pkg::OP_FILL;
    it.instruction = $urandom;
    it.inst_address = rand64();
    it.base_value = rand64();
    it.fill_index = idx;
    it.fill_data = data;
    return it;
  endfunction

  function automatic ale_pkg::in_item_t mk_load(logic [31:0] ins, logic [63:0] pc,
                                                logic [63:0] base);
    ale_pkg::in_item_t it;
    it.opcode = ale_pkg::OP_EMULATE;
    it.instruction = ins;
    it.inst_address = pc;
    it.base_value = base;
    it.fill_index = 9'($urandom);
    it.fill_data = rand64();
    return it;
  endfunction

  // random well-formed load aimed mostly inside the current window
  function automatic ale_pkg::in_item_t gen_load();
    logic [31:0] ins;
    logic [4:0]  rt, rn, rt2;
    logic [11:0] imm12;
    logic [8:0]  imm9;
    logic [6:0]  imm7;
    logic [18:0] imm19;
    logic [63:0] contrib, addr, pc, base, wsize;
    int          s, n, pick;
    bit          lit;
    rt = 5'($urandom); rn = 5'($urandom); rt2 = 5'($urandom);
    imm12 = 12'($urandom); imm9 = 9'($urandom); imm7 = 7'($urandom);
    imm19 = 19'($urandom);
    lit = 0;
    s = 8;
    n = 0;
    contrib = '0;
    case ($urandom_range(0, 12))
      0: begin
        ins = ale_pkg::LdrUoff64 | {10'b0, imm12, rn, rt}; contrib = 64'(imm12) * 8;
      end
      1: begin
        ins = ale_pkg::LdrUoff32 | {10'b0, imm12, rn, rt}; s = 4; contrib = 64'(imm12) * 4;
      end
      2: begin
        ins = ale_pkg::LdrPre64 | {11'b0, imm9, 2'b0, rn, rt}; contrib = sext(64'(imm9), 9);
      end
      3: begin
        ins = ale_pkg::LdrPre32 | {11'b0, imm9, 2'b0, rn, rt}; s = 4;
        contrib = sext(64'(imm9), 9);
      end
      4: ins = ale_pkg::LdrPost64 | {11'b0, imm9, 2'b0, rn, rt};
      5: begin ins = ale_pkg::LdrPost32 | {11'b0, imm9, 2'b0, rn, rt}; s = 4; end
      6: begin
        ins = ale_pkg::Ldur64 | {11'b0, imm9, 2'b0, rn, rt}; contrib = sext(64'(imm9), 9);
      end
      7: begin
        ins = ale_pkg::Ldur32 | {11'b0, imm9, 2'b0, rn, rt}; s = 4;
        contrib = sext(64'(imm9), 9);
      end
      8: begin
        ins = ale_pkg::LdrLit64 | {8'b0, imm19, rt}; lit = 1;
        contrib = sext(64'(imm19), 19) * 4;
      end
      9: begin
        ins = ale_pkg::LdrLit32 | {8'b0, imm19, rt}; s = 4; lit = 1;
        contrib = sext(64'(imm19), 19) * 4;
      end
      10: begin
        ins = ale_pkg::LdrswLit | {8'b0, imm19, rt}; s = 4; lit = 1;
        contrib = sext(64'(imm19), 19) * 4;
      end
      11: begin
        ins = ale_pkg::Ldp64 | {10'b0, imm7, rt2, rn, rt}; n = 16;
        contrib = sext(64'(imm7), 7) * 8;
      end
      default: begin
        ins = ale_pkg::Ldp32 | {10'b0, imm7, rt2, rn, rt}; s = 4; n = 8;
        contrib = sext(64'(imm7), 7) * 4;
      end
    endcase
    if (n == 0) n = s;
    wsize = (win_bytes > WINDOW_MAX) ? 64'(WINDOW_MAX) : 64'(win_bytes);
    pick = $urandom_range(0, 99);
    if (pick < 80 && wsize >= 64'(n))
      addr = win_base + 64'($urandom_range(0, int'(wsize) - n));
    else if (pick < 92)
      // right at the end of the window, or one byte past it
      addr = win_base + wsize - 64'(n) + 64'($urandom_range(0, 1));
    else
      addr = rand64();
    pc = rand64();
    base = rand64();
    if (lit) pc = addr - contrib;
    else base = addr - contrib;
    return mk_load(ins, pc, base);
  endfunction

  task automatic add_row(ale_pkg::in_item_t it, bit typed, ale_pkg::out_item_t res);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.result = res;
    dir_tab.push_back(row);
  endtask

  // one input transaction, with optional random gap before it
  task automatic send_item(ale_pkg::in_item_t it, bit typed, ale_pkg::out_item_t res);
    ale_pkg::out_item_t p;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_item = it;
    push = 1'b1;
    do @(posedge clk); while (full);
    p = predict_load(it);
    pending_loads.push_back(typed ? res : p);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic write_reg(ale_pkg::cfg_index_t idx, logic [63:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ale_pkg::CFG_WINDOW_BASE) win_base = data;
    else win_bytes = data[12:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until every expected result has come, then let the pipeline settle
  task automatic drain();
    while (pending_loads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: pop with random stalls and the requested long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // compare each popped transaction with the oldest prediction
  always @(posedge clk) begin
    ale_pkg::out_item_t e;
    if (!rst && pop && !empty) begin
      if (pending_loads.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_item);
        errors++;
      end else begin
        e = pending_loads.pop_front();
        n_checked++;
        if (e.handled) n_handled++;
        check_field("handled", 64'(e.handled), 64'(out_item.handled));
        check_field("dest1_enable", 64'(e.dest1_enable), 64'(out_item.dest1_enable));
        check_field("dest1_index", 64'(e.dest1_index), 64'(out_item.dest1_index));
        check_field("dest1_value", e.dest1_value, out_item.dest1_value);
        check_field("dest2_enable", 64'(e.dest2_enable), 64'(out_item.dest2_enable));
        check_field("dest2_index", 64'(e.dest2_index), 64'(out_item.dest2_index));
        check_field("dest2_value", e.dest2_value, out_item.dest2_value);
        check_field("writeback_enable", 64'(e.writeback_enable),
                    64'(out_item.writeback_enable));
        check_field("writeback_index", 64'(e.writeback_index),
                    64'(out_item.writeback_index));
        check_field("writeback_value", e.writeback_value, out_item.writeback_value);
        check_field("next_pc", e.next_pc, out_item.next_pc);
      end
    end
  end

  // main sequence
  initial begin
    ale_pkg::out_item_t none;
    ale_pkg::out_item_t typed_res;
    ale_pkg::in_item_t  it;
    logic [63:0] pbase [NUM_PHASES];
    logic [12:0] pbytes [NUM_PHASES];
    int          pick;
    errors = 0;
    cycles = 0;
    n_checked = 0;
    n_handled = 0;
    hold_req = 0;
    idle_on = 1'b1;
    none = '0;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = ale_pkg::CFG_WINDOW_BASE;
    cfg_data = '0;
    win_base = '0;
    win_bytes = 13'd4096;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(ale_pkg::CFG_WINDOW_BASE, 64'd0);
    write_reg(ale_pkg::CFG_WINDOW_BYTES, {$urandom, 19'($urandom), 13'd4096});

    // fill the whole store first; results held back so the block backs up
    hold_req = 300;
    for (int i = 0; i < STORE_WORDS; i++)
      send_item(mk_fill(i[8:0], rand64()), 0, none);

    // directed cases: window 0..4095
    typed_res = '0;
    typed_res.next_pc = 64'h1000;
    it = mk_fill(9'd0, 64'h8877_6655_4433_2211);
    it.inst_address = 64'h1000;
    add_row(it, 1, typed_res);
    typed_res = '0;
    typed_res.handled = 1; typed_res.dest1_enable = 1; typed_res.dest1_index = 5'd1;
    typed_res.dest1_value = 64'h8877_6655_4433_2211; typed_res.next_pc = 64'h2004;
    add_row(mk_load(ale_pkg::LdrUoff64 | 32'd1, 64'h2000, 64'd0), 1, typed_res);
    // unmatched encoding
    typed_res = '0;
    typed_res.next_pc = 64'hFFFF_FFFF_FFFF_FFFC;
    add_row(mk_load(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFC, 64'd0), 1, typed_res);
    // largest unsigned offset, far outside the window
    typed_res = '0;
    typed_res.next_pc = 64'h40;
    add_row(mk_load(ale_pkg::LdrUoff64 | {10'b0, 12'hFFF, 5'd2, 5'd3}, 64'h40, 64'd0),
            1, typed_res);
    // pc at the top wraps to zero when handled
    add_row(mk_load(ale_pkg::LdrUoff32 | {10'b0, 12'd1023, 5'd4, 5'd30},
                    64'hFFFF_FFFF_FFFF_FFFC, 64'd0), 0, none);
    add_row(mk_fill(9'd511, 64'h8000_0000_FFFF_FFFF), 0, none);
    add_row(mk_load(ale_pkg::LdrUoff64 | {10'b0, 12'd511, 5'd31, 5'd31}, 64'd8, 64'd0),
            0, none);
    // pre-index with sp base, negative offset, and last byte edge
    add_row(mk_load(ale_pkg::LdrPre64 | {11'b0, 9'h1F8, 2'b0, 5'd31, 5'd7}, 64'd0, 64'd4096),
            0, none);
    add_row(mk_load(ale_pkg::LdrPre32 | {11'b0, 9'h0FF, 2'b0, 5'd8, 5'd9}, 64'd0, 64'd3841),
            0, none);
    add_row(mk_load(ale_pkg::LdrPre64 | {11'b0, 9'h100, 2'b0, 5'd10, 5'd11}, 64'd0, 64'd256),
            0, none);
    add_row(mk_load(ale_pkg::LdrPost64 | {11'b0, 9'h100, 2'b0, 5'd12, 5'd13}, 64'd0,
                    64'd4088), 0, none);
    add_row(mk_load(ale_pkg::LdrPost32 | {11'b0, 9'h0FF, 2'b0, 5'd31, 5'd14}, 64'd0,
                    64'd4093), 0, none);
    add_row(mk_load(ale_pkg::Ldur64 | {11'b0, 9'h1FF, 2'b0, 5'd15, 5'd16}, 64'd0, 64'd1),
            0, none);
    add_row(mk_load(ale_pkg::Ldur32 | {11'b0, 9'h001, 2'b0, 5'd17, 5'd18}, 64'd0, 64'd4091),
            0, none);
    // literal loads, sign extension from the last word
    add_row(mk_load(ale_pkg::LdrLit64 | {8'b0, 19'h7FFFF, 5'd19}, 64'd12, 64'd0), 0, none);
    add_row(mk_load(ale_pkg::LdrLit32 | {8'b0, 19'h3FFFF, 5'd20}, 64'd4, 64'd0), 0, none);
    add_row(mk_load(ale_pkg::LdrswLit | {8'b0, 19'd1, 5'd21}, 64'd4088, 64'd0), 0, none);
    add_row(mk_load(ale_pkg::LdrswLit | {8'b0, 19'd0, 5'd22}, 64'd4092, 64'd0), 0, none);
    // load pairs: equal destinations, rt2 of 31, extreme offsets
    add_row(mk_load(ale_pkg::Ldp64 | {10'b0, 7'h40, 5'd23, 5'd24, 5'd23}, 64'd0, 64'd512),
            0, none);
    add_row(mk_load(ale_pkg::Ldp32 | {10'b0, 7'h3F, 5'd31, 5'd25, 5'd26}, 64'd0, 64'd3836),
            0, none);
    add_row(mk_load(ale_pkg::Ldp64 | {10'b0, 7'h01, 5'd27, 5'd28, 5'd29}, 64'd0, 64'd4072),
            0, none);
    foreach (dir_tab[i])
      send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].result);

    // random phases across window settings, extremes included
    pbase[0] = rand64();                 pbytes[0] = 13'd4096;
    pbase[1] = 64'hFFFF_FFFF_FFFF_F800;  pbytes[1] = 13'd4096;
    pbase[2] = 64'hFFFF_FFFF_FFFF_FFFF;  pbytes[2] = 13'h1FFF;
    pbase[3] = rand64();                 pbytes[3] = 13'd0;
    pbase[4] = rand64();                 pbytes[4] = 13'd1;
    pbase[5] = rand64();                 pbytes[5] = 13'($urandom);
    pbase[6] = 64'd0;                    pbytes[6] = 13'd4095;
    pbase[7] = rand64();                 pbytes[7] = 13'd4096;
    for (int p = 0; p < NUM_PHASES; p++) begin
      // sender waits for every result before reconfiguring
      drain();
      write_reg(ale_pkg::CFG_WINDOW_BASE, pbase[p]);
      write_reg(ale_pkg::CFG_WINDOW_BYTES, {$urandom, 19'($urandom), pbytes[p]});
      if (p == 3) hold_req = 200;
      idle_on = (p < NUM_PHASES - 1);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) it = mk_fill(9'($urandom), rand64());
        else if (pick < 22) it = mk_load($urandom, rand64(), rand64());
        else it = gen_load();
        send_item(it, 0, none);
      end
    end

    drain();
    $display("covered %0d results, %0d of them handled loads, over %0d window settings",
             n_checked, n_handled, NUM_PHASES + 1);
    $display("%0d mismatches", errors);
    if (errors == 0 && pending_loads.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
